// File: design/pcfsk_pkg.sv
`timescale 1ns / 1ps
// pcfsk_pkg: shared constants and a helper function for the pulse-count fsk receiver
// depends on nothing; imported by pulse_count_fsk_receiver_top
package pcfsk_pkg;

    // edge period windows for the sync search
    localparam logic [15:0] HI_PER_MIN = 16'd320;
    localparam logic [15:0] HI_PER_MAX = 16'd380;
    localparam logic [15:0] LO_PER_MIN = 16'd400;
    localparam logic [15:0] LO_PER_MAX = 16'd500;

    // timing limits in milliseconds
    localparam logic [31:0] LOW_WINDOW_MS = 32'd50;
    localparam logic [31:0] GAP_MS        = 32'd10;

    // group counts
    localparam logic [7:0] GROUPS_NEEDED = 8'd14;
    localparam logic [7:0] GROUPS_EARLY  = 8'd3;

    // bit values from sample classification
    localparam logic [2:0] BIT_ONE      = 3'd1;
    localparam logic [2:0] BIT_ZERO     = 3'd0;
    localparam logic [2:0] INVALID_BITS = 3'd7;

    // framing characters
    localparam logic [7:0] FILL_BYTE = 8'd253;
    localparam logic [7:0] CH_STX    = 8'h02;
    localparam logic [7:0] CH_ETX    = 8'h03;
    localparam logic [7:0] CH_EOT    = 8'h04;

    // operation codes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic CFG_HIGH_THRESHOLD = 1'b0;
    localparam logic CFG_LOW_THRESHOLD  = 1'b1;

    // reset values of the configuration registers
    localparam logic [7:0] HIGH_THRESHOLD_RST = 8'd56;
    localparam logic [7:0] LOW_THRESHOLD_RST  = 8'd44;

    // reciprocal of 7 in 11 fractional bits, exact floor for 8-bit inputs
    localparam logic [8:0] RECIP7      = 9'd293;
    localparam int         RECIP7_BITS = 11;

    // level of a threshold: x - floor(x / 7)
    function automatic logic [7:0] level_of(input logic [7:0] x);
        logic [16:0] prod;
        logic [7:0]  quot;
        begin
            prod = {9'd0, x} * {8'd0, RECIP7};
            quot = {2'd0, prod[RECIP7_BITS +: 6]};
            return x - quot;
        end
    endfunction

endpackage

// File: design/pulse_count_fsk_receiver_top.sv
`timescale 1ns / 1ps
// Pulse-count FSK receiver. Takes one item per clock cycle (edge event or sample tick);
// a result, when an item makes one, is registered after the item is accepted: the
// accepting edge loads the input register and the decode logic loads the result register
// once it is free. The sustained rate of one item per cycle holds as long as out_stall
// stays low; a stalled result holds the input register and then in_stall. Thresholds are
// written through the cfg port (index 0 high, index 1 low) and take effect on the next item.
// pulse_count_fsk_receiver_top: sync search, bit sampling and stx/etx/eot framing
// depends on pcfsk_pkg
module pulse_count_fsk_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [15:0] edge_period,
    input  logic [31:0] time_ms,
    input  logic [15:0] pulse_count,
    // result item channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic        is_check,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import pcfsk_pkg::*;

    // configuration
    logic [7:0] high_threshold_reg;
    logic [7:0] low_threshold_reg;

    // input register
    logic        s1_valid_reg;
    logic        op_reg;
    logic [15:0] period_reg;
    logic [31:0] time_reg;
    logic [15:0] count_reg;

    // receiver state
    logic        sync_phase_reg, sync_phase_next;
    logic [7:0]  edge_run_reg, edge_run_next;
    logic [7:0]  high_groups_reg, high_groups_next;
    logic [31:0] last_edge_time_reg, last_edge_time_next;
    logic [31:0] high_done_time_reg, high_done_time_next;
    logic        sampling_on_reg, sampling_on_next;
    logic [2:0]  bit_position_reg, bit_position_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [7:0]  invalid_samples_reg, invalid_samples_next;
    logic        in_text_reg, in_text_next;
    logic        expect_check_reg, expect_check_next;

    // result register
    logic        out_valid_reg;
    logic [7:0]  data_byte_reg;
    logic        is_check_reg;

    // decode outputs
    logic        emit;
    logic [7:0]  emit_byte;
    logic        emit_check;

    // handshake control
    logic out_free;
    logic s1_adv;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign data_byte = data_byte_reg;
    assign is_check  = is_check_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_threshold_reg <= HIGH_THRESHOLD_RST;
            low_threshold_reg  <= LOW_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_HIGH_THRESHOLD)
                high_threshold_reg <= cfg_data;
            else
                low_threshold_reg <= cfg_data;
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg     <= operation;
            period_reg <= edge_period;
            time_reg   <= time_ms;
            count_reg  <= pulse_count;
        end
    end

    // decode of one item against the current state
    always_comb
    begin
        logic [31:0] gap;
        logic        hi_per;
        logic        lo_ok;
        logic [7:0]  hi_level;
        logic [7:0]  lo_level;
        logic [2:0]  bitval;
        logic [10:0] bit_shifted;
        logic [7:0]  byte_val;

        sync_phase_next      = sync_phase_reg;
        edge_run_next        = edge_run_reg;
        high_groups_next     = high_groups_reg;
        last_edge_time_next  = last_edge_time_reg;
        high_done_time_next  = high_done_time_reg;
        sampling_on_next     = sampling_on_reg;
        bit_position_next    = bit_position_reg;
        shift_byte_next      = shift_byte_reg;
        invalid_samples_next = invalid_samples_reg;
        in_text_next         = in_text_reg;
        expect_check_next    = expect_check_reg;
        emit       = 1'b0;
        emit_byte  = shift_byte_reg;
        emit_check = 1'b0;

        gap         = time_reg - last_edge_time_reg;
        hi_per      = (period_reg > HI_PER_MIN) && (period_reg < HI_PER_MAX);
        lo_ok       = ((time_reg - high_done_time_reg) < LOW_WINDOW_MS)
                      && (period_reg > LO_PER_MIN) && (period_reg < LO_PER_MAX);
        hi_level    = level_of(high_threshold_reg);
        lo_level    = level_of(low_threshold_reg);
        bitval      = BIT_ZERO;
        bit_shifted = '0;
        byte_val    = '0;

        if (op_reg == OP_EDGE)
        begin
            // sync search
            last_edge_time_next = time_reg;
            if (!sync_phase_reg)
            begin
                // high-frequency groups
                if (hi_per)
                    edge_run_next = edge_run_reg + 8'd1;
                else if (gap > GAP_MS)
                begin
                    high_groups_next = '0;
                    edge_run_next    = '0;
                end
                if (edge_run_next >= high_threshold_reg)
                begin
                    high_groups_next = high_groups_next + 8'd1;
                    edge_run_next    = '0;
                end
                if ((high_groups_next > GROUPS_EARLY) && (period_reg > LO_PER_MIN))
                    high_groups_next = '0;
                if (high_groups_next > GROUPS_NEEDED)
                begin
                    high_done_time_next = time_reg;
                    sync_phase_next     = 1'b1;
                    edge_run_next       = '0;
                end
            end
            else
            begin
                // low-frequency run within the window
                if (lo_ok)
                    edge_run_next = edge_run_reg + 8'd1;
                else
                begin
                    high_groups_next = '0;
                    edge_run_next    = '0;
                    sync_phase_next  = 1'b0;
                end
                if (edge_run_next >= low_threshold_reg)
                begin
                    high_groups_next  = '0;
                    edge_run_next     = '0;
                    sync_phase_next   = 1'b0;
                    sampling_on_next  = 1'b1;
                    bit_position_next = '0;
                    shift_byte_next   = '0;
                end
            end
        end
        else if (sampling_on_reg)
        begin
            // classify the pulse count
            if ({8'd0, hi_level} < count_reg)
                bitval = BIT_ONE;
            else if ({8'd0, lo_level} < count_reg)
                bitval = BIT_ZERO;
            else
            begin
                bitval               = INVALID_BITS;
                invalid_samples_next = invalid_samples_reg + 8'd1;
            end

            // merge into the byte at the current position
            bit_shifted = {8'd0, bitval} << (3'd7 - bit_position_reg);
            byte_val    = shift_byte_reg ^ bit_shifted[7:0];

            if (bit_position_reg == 3'd7)
            begin
                bit_position_next = '0;
                shift_byte_next   = '0;
                emit_byte         = byte_val;
                // framing of a completed byte
                if (byte_val != FILL_BYTE)
                begin
                    if (expect_check_reg)
                    begin
                        sampling_on_next  = 1'b0;
                        expect_check_next = 1'b0;
                        emit              = 1'b1;
                        emit_check        = 1'b1;
                    end
                    else if (byte_val == CH_STX)
                        in_text_next = 1'b1;
                    else if ((byte_val == CH_ETX) || (byte_val == CH_EOT))
                    begin
                        in_text_next      = 1'b0;
                        expect_check_next = 1'b1;
                    end
                    else if (in_text_reg)
                        emit = 1'b1;
                end
            end
            else
            begin
                bit_position_next = bit_position_reg + 3'd1;
                shift_byte_next   = byte_val;
            end

            // too many invalid samples ends sampling
            if (invalid_samples_next > hi_level)
            begin
                invalid_samples_next = '0;
                sampling_on_next     = 1'b0;
                bit_position_next    = '0;
            end
        end
    end

    // receiver state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_phase_reg      <= 1'b0;
            edge_run_reg        <= '0;
            high_groups_reg     <= '0;
            last_edge_time_reg  <= '0;
            high_done_time_reg  <= '0;
            sampling_on_reg     <= 1'b0;
            bit_position_reg    <= '0;
            shift_byte_reg      <= '0;
            invalid_samples_reg <= '0;
            in_text_reg         <= 1'b0;
            expect_check_reg    <= 1'b0;
        end
        else if (s1_adv)
        begin
            sync_phase_reg      <= sync_phase_next;
            edge_run_reg        <= edge_run_next;
            high_groups_reg     <= high_groups_next;
            last_edge_time_reg  <= last_edge_time_next;
            high_done_time_reg  <= high_done_time_next;
            sampling_on_reg     <= sampling_on_next;
            bit_position_reg    <= bit_position_next;
            shift_byte_reg      <= shift_byte_next;
            invalid_samples_reg <= invalid_samples_next;
            in_text_reg         <= in_text_next;
            expect_check_reg    <= expect_check_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_adv && emit;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv && emit)
        begin
            data_byte_reg <= emit_byte;
            is_check_reg  <= emit_check;
        end
    end

endmodule
